// File: sv/bsps_pkg.sv
// ----------------------------------------------------------------------------
// bsps_pkg
// shared types and constants of the brush stamp paint store
// ----------------------------------------------------------------------------
package bsps_pkg;

  localparam int unsigned DefWidth    = 1200;
  localparam int unsigned DefHeight   = 800;
  localparam int unsigned DefMaxBrush = 128;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned PosXW    = 11;
  localparam int unsigned PosYW    = 10;
  localparam int unsigned ColorW   = 3;
  localparam int unsigned BrushW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // half width of the brush, brush_size / 2 of an 8-bit size
  localparam int unsigned HalfW    = BrushW - 1;
  localparam int unsigned RootOpW  = 2 * HalfW;
  // signed offset from the cursor
  localparam int unsigned OffW     = HalfW + 1;
  // signed point coordinate before clamping
  localparam int unsigned CoordW   = 14;
  // store entry: painted flag on top of the stroke color
  localparam int unsigned EntryW   = ColorW + 1;

  typedef enum logic [ModeW-1:0] {
    MODE_STAMP = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } bsps_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRUSH_SIZE = 2'd0,
    CFG_ROUND      = 2'd1,
    CFG_PEN        = 2'd2,
    CFG_BACKGROUND = 2'd3
  } bsps_cfg_e;

  typedef struct packed {
    logic                     valid;
    logic                     rd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } bsps_point_t;

endpackage

// File: sv/brush_stamp_paint_store.sv
// ----------------------------------------------------------------------------
// brush_stamp_paint_store
// per-pixel paint store with square and round brush stamps, clear and read
// ----------------------------------------------------------------------------
// One item is handled at a time and every item returns one result beat. The
// store has one write port, so a stamp writes one painted point per cycle
// into the address pipeline and then waits for it to drain; for a round stamp
// each of the 2h+1 columns first runs a bit-serial square root ahead of its
// 2r+1 rows. A clear item sweeps the whole store, and the same sweep runs
// once after reset with the input stalled; configuration writes are taken
// throughout. The result is held in an output register, so the next item is
// taken while it waits.
module brush_stamp_paint_store #(
  parameter int unsigned WIDTH     = bsps_pkg::DefWidth,
  parameter int unsigned HEIGHT    = bsps_pkg::DefHeight,
  parameter int unsigned MAX_BRUSH = bsps_pkg::DefMaxBrush
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsps_pkg::ModeW-1:0]    mode_i,
  input  logic [bsps_pkg::PosXW-1:0]    pos_x_i,
  input  logic [bsps_pkg::PosYW-1:0]    pos_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsps_pkg::ColorW-1:0]   shown_color_o,
  output logic                          is_painted_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bsps_pkg::CfgDataW-1:0] cfg_data_i
);
  import bsps_pkg::*;

  localparam int unsigned Depth = WIDTH * HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  // configuration registers
  logic [BrushW-1:0] brush_q;
  logic              round_q;
  logic [ColorW-1:0] pen_q;
  logic [ColorW-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_q <= BrushW'(8);
      round_q <= 1'b0;
      pen_q   <= ColorW'(7);
      bg_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BRUSH_SIZE: brush_q <= cfg_data_i[BrushW-1:0];
        CFG_ROUND:      round_q <= cfg_data_i[0];
        CFG_PEN:        pen_q   <= cfg_data_i[ColorW-1:0];
        CFG_BACKGROUND: bg_q    <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  bsps_point_t        point;
  logic               busy;
  logic               clr_we;
  logic [AW-1:0]      clr_addr;
  logic               root_start;
  logic [RootOpW-1:0] root_operand;
  logic               root_done;
  logic [HalfW-1:0]   root;
  logic               out_free;
  logic               res_valid;
  logic               res_rd;
  logic               pt_we, pt_re;
  logic [AW-1:0]      pt_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [EntryW-1:0]  mem_wdata;
  logic [EntryW-1:0]  mem_rdata;

  bsps_ctrl #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .MAX_BRUSH (MAX_BRUSH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .brush_size_i   (brush_q),
    .round_brush_i  (round_q),
    .point_o        (point),
    .busy_i         (busy),
    .clr_we_o       (clr_we),
    .clr_addr_o     (clr_addr),
    .root_start_o   (root_start),
    .root_operand_o (root_operand),
    .root_done_i    (root_done),
    .root_i         (root),
    .out_free_i     (out_free),
    .res_valid_o    (res_valid),
    .res_rd_o       (res_rd)
  );

  bsps_isqrt #(
    .RW (HalfW)
  ) u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .operand_i (root_operand),
    .done_o    (root_done),
    .root_o    (root)
  );

  bsps_addr #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point),
    .we_o    (pt_we),
    .re_o    (pt_re),
    .addr_o  (pt_addr),
    .busy_o  (busy)
  );

  // sweep has the port to itself while it runs
  assign mem_we    = clr_we | pt_we;
  assign mem_addr  = clr_we ? clr_addr : pt_addr;
  assign mem_wdata = clr_we ? '0 : {1'b1, pen_q};

  bsps_ram #(
    .DW    (EntryW),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (pt_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ColorW-1:0] shown_q, shown_d;
  logic              painted_q, painted_d;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    shown_d     = shown_q;
    painted_d   = painted_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      if (!res_rd) begin
        shown_d   = '0;
        painted_d = 1'b0;
      end else if (mem_rdata[EntryW-1]) begin
        shown_d   = mem_rdata[ColorW-1:0];
        painted_d = 1'b1;
      end else begin
        shown_d   = bg_q;
        painted_d = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shown_q   <= shown_d;
    painted_q <= painted_d;
  end

  assign out_valid_o   = out_valid_q;
  assign shown_color_o = shown_q;
  assign is_painted_o  = painted_q;

endmodule

// File: sv/bsps_ram.sv
// ----------------------------------------------------------------------------
// bsps_ram
// generic single clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module bsps_ram #(
  parameter int unsigned DW    = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bsps_isqrt.sv
// ----------------------------------------------------------------------------
// bsps_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module bsps_isqrt #(
  parameter int unsigned RW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] operand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned BW = $clog2(RW);

  logic            running_q, running_d;
  logic            done_q, done_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [RW-1:0]   root_q, root_d;
  logic [2*RW-1:0] val_q, val_d;
  logic [RW-1:0]   trial;
  logic [2*RW-1:0] trial_sq;

  assign trial    = root_q | (RW'(1) << bit_q);
  assign trial_sq = (2*RW)'(trial) * (2*RW)'(trial);

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    bit_d     = bit_q;
    root_d    = root_q;
    val_d     = val_q;
    if (start_i) begin
      running_d = 1'b1;
      bit_d     = BW'(RW - 1);
      root_d    = '0;
      val_d     = operand_i;
    end else if (running_q) begin
      if (trial_sq <= val_q) begin
        root_d = trial;
      end
      if (bit_q == '0) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end else begin
        bit_d = bit_q - BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: sv/bsps_addr.sv
// ----------------------------------------------------------------------------
// bsps_addr
// point to store address pipeline: edge clamp, then row times width plus column
// ----------------------------------------------------------------------------
module bsps_addr #(
  parameter int unsigned WIDTH  = bsps_pkg::DefWidth,
  parameter int unsigned HEIGHT = bsps_pkg::DefHeight
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsps_pkg::bsps_point_t             point_i,
  output logic                              we_o,
  output logic                              re_o,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]   addr_o,
  output logic                              busy_o
);
  import bsps_pkg::*;

  localparam int unsigned XW = $clog2(WIDTH);
  localparam int unsigned YW = $clog2(HEIGHT);
  localparam int unsigned AW = $clog2(WIDTH*HEIGHT);

  localparam logic signed [CoordW-1:0] XMax = CoordW'(WIDTH - 1);
  localparam logic signed [CoordW-1:0] YMax = CoordW'(HEIGHT - 1);

  logic          a_valid_q, a_rd_q;
  logic [XW-1:0] ax_q, ax_d;
  logic [YW-1:0] ay_q, ay_d;
  logic          b_we_q, b_re_q;
  logic [AW-1:0] addr_q;

  always_comb begin
    if (point_i.x < 0) begin
      ax_d = '0;
    end else if (point_i.x > XMax) begin
      ax_d = XMax[XW-1:0];
    end else begin
      ax_d = point_i.x[XW-1:0];
    end
    if (point_i.y < 0) begin
      ay_d = '0;
    end else if (point_i.y > YMax) begin
      ay_d = YMax[YW-1:0];
    end else begin
      ay_d = point_i.y[YW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_we_q    <= 1'b0;
      b_re_q    <= 1'b0;
    end else begin
      a_valid_q <= point_i.valid;
      b_we_q    <= a_valid_q & ~a_rd_q;
      b_re_q    <= a_valid_q & a_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rd_q <= point_i.rd;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    addr_q <= AW'(ay_q) * AW'(WIDTH) + AW'(ax_q);
  end

  assign we_o   = b_we_q;
  assign re_o   = b_re_q;
  assign addr_o = addr_q;
  assign busy_o = a_valid_q | b_we_q | b_re_q;

endmodule

// File: sv/bsps_ctrl.sv
// ----------------------------------------------------------------------------
// bsps_ctrl
// item sequencer: stamp column and row walk, clearing sweep, pixel read
// ----------------------------------------------------------------------------
module bsps_ctrl #(
  parameter int unsigned WIDTH     = bsps_pkg::DefWidth,
  parameter int unsigned HEIGHT    = bsps_pkg::DefHeight,
  parameter int unsigned MAX_BRUSH = bsps_pkg::DefMaxBrush
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bsps_pkg::ModeW-1:0]        mode_i,
  input  logic [bsps_pkg::PosXW-1:0]        pos_x_i,
  input  logic [bsps_pkg::PosYW-1:0]        pos_y_i,
  input  logic [bsps_pkg::BrushW-1:0]       brush_size_i,
  input  logic                              round_brush_i,
  output bsps_pkg::bsps_point_t             point_o,
  input  logic                              busy_i,
  output logic                              clr_we_o,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]   clr_addr_o,
  output logic                              root_start_o,
  output logic [bsps_pkg::RootOpW-1:0]      root_operand_o,
  input  logic                              root_done_i,
  input  logic [bsps_pkg::HalfW-1:0]        root_i,
  input  logic                              out_free_i,
  output logic                              res_valid_o,
  output logic                              res_rd_o
);
  import bsps_pkg::*;

  localparam int unsigned AW = $clog2(WIDTH*HEIGHT);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_COL   = 8'b0000_0100,
    S_ROOT  = 8'b0000_1000,
    S_ROWS  = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } bsps_state_e;

  bsps_state_e             state_q, state_d;
  logic [PosXW-1:0]        cx_q, cx_d;
  logic [PosYW-1:0]        cy_q, cy_d;
  logic signed [OffW-1:0]  dx_q, dx_d;
  logic signed [OffW-1:0]  dy_q, dy_d;
  logic [HalfW-1:0]        r_q, r_d;
  logic [RootOpW-1:0]      hh_q, hh_d;
  logic                    rd_q, rd_d;
  logic                    clr_item_q, clr_item_d;
  logic [AW-1:0]           clr_cnt_q, clr_cnt_d;

  logic [BrushW:0]         size_lim;
  logic [HalfW-1:0]        h;
  logic signed [OffW-1:0]  h_s, r_s;
  logic [HalfW-1:0]        adx;

  assign size_lim = ({1'b0, brush_size_i} > (BrushW+1)'(MAX_BRUSH)) ?
                    (BrushW+1)'(MAX_BRUSH) : {1'b0, brush_size_i};
  assign h   = size_lim[HalfW:1];
  assign h_s = $signed({1'b0, h});
  assign r_s = $signed({1'b0, r_q});
  assign adx = dx_q[OffW-1] ? HalfW'(-dx_q) : dx_q[HalfW-1:0];

  assign root_operand_o = hh_q - RootOpW'(RootOpW'(adx) * RootOpW'(adx));

  always_comb begin
    state_d      = state_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    r_d          = r_q;
    hh_d         = hh_q;
    rd_d         = rd_q;
    clr_item_d   = clr_item_q;
    clr_cnt_d    = clr_cnt_q;
    root_start_o = 1'b0;
    res_valid_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cx_d = pos_x_i;
          cy_d = pos_y_i;
          rd_d = 1'b0;
          case (mode_i)
            MODE_STAMP: begin
              dx_d    = -h_s;
              hh_d    = RootOpW'(h) * RootOpW'(h);
              state_d = S_COL;
            end
            MODE_CLEAR: begin
              clr_cnt_d  = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLEAR;
            end
            MODE_READ: begin
              dx_d    = '0;
              dy_d    = '0;
              rd_d    = 1'b1;
              state_d = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(WIDTH*HEIGHT - 1)) begin
          clr_item_d = 1'b0;
          state_d    = clr_item_q ? S_DONE : S_IDLE;
        end
      end
      S_COL: begin
        if (round_brush_i) begin
          root_start_o = 1'b1;
          state_d      = S_ROOT;
        end else begin
          r_d     = h;
          dy_d    = -h_s;
          state_d = S_ROWS;
        end
      end
      S_ROOT: begin
        if (root_done_i) begin
          r_d     = root_i;
          dy_d    = -$signed({1'b0, root_i});
          state_d = S_ROWS;
        end
      end
      S_ROWS: begin
        if (dy_q == r_s) begin
          if (dx_q == h_s) begin
            state_d = S_DRAIN;
          end else begin
            dx_d = dx_q + OffW'(1);
            if (round_brush_i) begin
              state_d = S_COL;
            end else begin
              dy_d = -r_s;
            end
          end
        end else begin
          dy_d = dy_q + OffW'(1);
        end
      end
      S_READ: begin
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!busy_i) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_item_q <= 1'b0;
      clr_cnt_q  <= '0;
      rd_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_item_q <= clr_item_d;
      clr_cnt_q  <= clr_cnt_d;
      rd_q       <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    r_q  <= r_d;
    hh_q <= hh_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign point_o.valid = (state_q == S_ROWS) || (state_q == S_READ);
  assign point_o.rd    = rd_q;
  assign point_o.x     = $signed(CoordW'(cx_q)) + CoordW'(dx_q);
  assign point_o.y     = $signed(CoordW'(cy_q)) + CoordW'(dy_q);
  assign clr_we_o      = (state_q == S_CLEAR);
  assign clr_addr_o    = clr_cnt_q;
  assign res_rd_o      = rd_q;

endmodule

// File: tb/tb_brush_stamp_paint_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brush_stamp_paint_store
// self-checking bench for the brush stamp paint store
// ----------------------------------------------------------------------------
// A canvas mirror in the bench keeps its own copy of the painted flags, stroke
// colors and brush registers, paints every accepted stamp and predicts the
// pixel beat of every item. Directed items hit the window corners, clamped
// coordinates, the unused mode, a clear and the brush size extremes; random
// phases then stamp and read back around the last cursor under changing brush
// settings, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_brush_stamp_paint_store;
  import bsps_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned MaxGap        = 8;
  localparam int unsigned HoldCycles    = 40000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned RandomPhases  = 5;
  localparam int unsigned PhaseItems    = 16;
  localparam int unsigned WatchdogLimit = 3 * DefWidth * DefHeight;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              painted;
  } pixel_t;

  class canvas_mirror;
    int                cols;
    int                rows;
    int                max_brush;
    bit                painted[];
    bit [ColorW-1:0]   stroke[];
    bit [BrushW-1:0]   brush_size;
    bit                round_tip;
    bit [ColorW-1:0]   pen;
    bit [ColorW-1:0]   background;
    pixel_t            due_pixels[$];
    int unsigned       mismatches;
    int unsigned       stamps;
    int unsigned       reads;
    int unsigned       hits;
    int unsigned       clears;
    int unsigned       spares;

    function new(int c, int r, int m);
      cols       = c;
      rows       = r;
      max_brush  = m;
      painted    = new[c * r];
      stroke     = new[c * r];
      brush_size = 8'd8;
      round_tip  = 1'b0;
      pen        = 3'd7;
      background = 3'd0;
    endfunction

    function int pixel_index(int x, int y);
      int cx;
      int cy;
      cx = (x < 0) ? 0 : (x > cols - 1) ? cols - 1 : x;
      cy = (y < 0) ? 0 : (y > rows - 1) ? rows - 1 : y;
      return cy * cols + cx;
    endfunction

    function void write_register(bsps_cfg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_BRUSH_SIZE: brush_size = value[BrushW-1:0];
        CFG_ROUND:      round_tip  = value[0];
        CFG_PEN:        pen        = value[ColorW-1:0];
        CFG_BACKGROUND: background = value[ColorW-1:0];
        default: ;
      endcase
    endfunction

    function int half_width();
      return ((brush_size > max_brush) ? max_brush : brush_size) / 2;
    endfunction

    function void absorb_item(logic [ModeW-1:0] mode, int x, int y);
      pixel_t px;
      int     h;
      int     dx;
      int     yy;
      int     reach;
      int     k;
      px = '0;
      case (mode)
        MODE_STAMP: begin
          stamps++;
          h = half_width();
          for (dx = -h; dx <= h; dx++) begin
            reach = h;
            if (round_tip) begin
              reach = 0;
              while ((reach + 1) * (reach + 1) <= h * h - dx * dx) reach++;
            end
            for (yy = y - reach; yy <= y + reach; yy++) begin
              k = pixel_index(x + dx, yy);
              painted[k] = 1'b1;
              stroke[k]  = pen;
            end
          end
        end
        MODE_CLEAR: begin
          clears++;
          foreach (painted[i]) painted[i] = 1'b0;
        end
        MODE_READ: begin
          reads++;
          k = pixel_index(x, y);
          if (painted[k]) begin
            hits++;
            px.color   = stroke[k];
            px.painted = 1'b1;
          end else begin
            px.color = background;
          end
        end
        default: spares++;
      endcase
      due_pixels.push_back(px);
    endfunction

    function void check_pixel(logic [ColorW-1:0] color, logic painted_bit);
      pixel_t want;
      if (due_pixels.size() == 0) begin
        $error("pixel beat with nothing expected: shown_color %0d, is_painted %0d",
               color, painted_bit);
        mismatches++;
        return;
      end
      want = due_pixels.pop_front();
      if (color !== want.color) begin
        $error("shown_color: expected %0d, got %0d", want.color, color);
        mismatches++;
      end
      if (painted_bit !== want.painted) begin
        $error("is_painted: expected %0d, got %0d", want.painted, painted_bit);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [ModeW-1:0]    mode_i        = '0;
  logic [PosXW-1:0]    pos_x_i       = '0;
  logic [PosYW-1:0]    pos_y_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b1;
  logic [ColorW-1:0]   shown_color_o;
  logic                is_painted_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  canvas_mirror canvas;
  bit           send_quiet = 1'b0;
  bit           sink_quiet = 1'b0;
  bit           hold_req   = 1'b0;
  int unsigned  settings   = 0;
  int unsigned  quiet_cycles = 0;

  brush_stamp_paint_store DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shown_color_o (shown_color_o),
    .is_painted_o  (is_painted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("timeout: no beat for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [ModeW-1:0] mode, input int x, input int y);
    int unsigned pause;
    pause = send_quiet ? 0 : $urandom_range(0, MaxGap);
    if (pause != 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    pos_x_i    <= x[PosXW-1:0];
    pos_y_i    <= y[PosYW-1:0];
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    canvas.absorb_item(mode_i, pos_x_i, pos_y_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (canvas.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_brush(input logic [BrushW-1:0] size, input bit tip,
                               input logic [ColorW-1:0] pen, input logic [ColorW-1:0] bg);
    bsps_cfg_e           regs[4];
    logic [CfgDataW-1:0] values[4];
    regs      = '{CFG_BRUSH_SIZE, CFG_ROUND, CFG_PEN, CFG_BACKGROUND};
    values[0] = size;
    values[1] = {7'($urandom), tip};
    values[2] = {5'($urandom), pen};
    values[3] = {5'($urandom), bg};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= regs[i];
      cfg_data_i  <= values[i];
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      canvas.write_register(regs[i], values[i]);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  initial begin : result_sink
    int unsigned pause;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pause = sink_quiet ? 0 : $urandom_range(0, MaxGap);
        if (pause != 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      canvas.check_pixel(shown_color_o, is_painted_o);
    end
  end

  initial begin : stimulus
    int          last_x;
    int          last_y;
    int          h;
    int          x;
    int          y;
    int unsigned pick;
    logic [BrushW-1:0] size;
    canvas = new(DefWidth, DefHeight, DefMaxBrush);
    last_x = 600;
    last_y = 400;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset brush: size 8 square, pen 7, background 0
    send_item(MODE_READ, 0, 0);
    send_item(MODE_STAMP, 600, 400);
    send_item(MODE_READ, 604, 404);
    send_item(MODE_READ, 605, 400);
    send_item(MODE_READ, 596, 396);
    send_item(MODE_STAMP, 0, 0);
    send_item(MODE_READ, 0, 0);
    send_item(MODE_READ, 2047, 1023);
    send_item(MODE_STAMP, 2047, 1023);
    send_item(MODE_READ, 1199, 799);
    send_item(ModeSpare, 100, 100);
    send_item(MODE_READ, 100, 100);
    send_item(MODE_CLEAR, 0, 0);
    send_item(MODE_READ, 600, 400);
    drain_results();

    // oversized round brush, disk edge probes
    program_brush(8'd255, 1'b1, 3'd2, 3'd5);
    send_item(MODE_STAMP, 600, 400);
    send_item(MODE_READ, 600, 464);
    send_item(MODE_READ, 664, 400);
    send_item(MODE_READ, 646, 444);
    send_item(MODE_READ, 646, 446);
    send_item(MODE_READ, 600, 465);
    drain_results();

    // zero brush paints a single pixel
    program_brush(8'd0, 1'b0, 3'd1, 3'd6);
    send_item(MODE_STAMP, 10, 10);
    send_item(MODE_READ, 10, 10);
    send_item(MODE_READ, 11, 10);
    send_item(MODE_READ, 630, 430);
    drain_results();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: program_brush(8'd128, 1'b0, 3'd0, 3'd7);
        1: program_brush(8'd1, 1'b1, 3'd7, 3'd0);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7)      size = BrushW'($urandom_range(0, 12));
          else if (pick < 9) size = BrushW'($urandom_range(13, 40));
          else               size = BrushW'($urandom_range(0, 255));
          program_brush(size, 1'($urandom), 3'($urandom), 3'($urandom));
        end
      endcase
      send_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        send_quiet = 1'b1;
        hold_req   = 1'b1;
      end
      h = canvas.half_width();
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          if ($urandom_range(0, 3) == 0) begin
            x = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                     : $urandom_range(DefWidth - 6, DefWidth - 1);
            y = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                     : $urandom_range(DefHeight - 6, DefHeight - 1);
          end else begin
            x = $urandom_range(0, DefWidth - 1);
            y = $urandom_range(0, DefHeight - 1);
          end
          last_x = x;
          last_y = y;
          send_item(MODE_STAMP, x, y);
        end else if (pick < 18) begin
          if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, (1 << PosXW) - 1);
            y = $urandom_range(0, (1 << PosYW) - 1);
          end else begin
            x = last_x + $urandom_range(0, 2 * h + 4) - (h + 2);
            y = last_y + $urandom_range(0, 2 * h + 4) - (h + 2);
            x = (x < 0) ? 0 : (x > DefWidth - 1) ? DefWidth - 1 : x;
            y = (y < 0) ? 0 : (y > DefHeight - 1) ? DefHeight - 1 : y;
          end
          send_item(MODE_READ, x, y);
        end else begin
          send_item(ModeSpare, $urandom_range(0, (1 << PosXW) - 1),
                    $urandom_range(0, (1 << PosYW) - 1));
        end
      end
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d stamps, %0d reads (%0d on painted pixels), %0d clears,",
             canvas.stamps, canvas.reads, canvas.hits, canvas.clears);
    $display("%0d unused-mode items, %0d brush settings, %0d mismatches",
             canvas.spares, settings, canvas.mismatches);
    if (canvas.mismatches == 0 && canvas.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
